FILE: rtl/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Types and constants for the round-robin run queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

   localparam int NUM_PROCS_DEFAULT = 64;
   localparam int PROC_W            = 6;
   localparam int SLICE_W           = 8;
   localparam int COUNT_W           = 7;
   localparam int MAX_IDS           = 2 ** PROC_W;

   localparam logic [SLICE_W-1:0] MAX_SLICE_RESET = 8'd5;

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PICK    = 2'd2,
      CMD_TICK    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_QUEUED     = 2'd1,
      STATUS_NOT_QUEUED = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type             command;
      logic [PROC_W-1:0]   proc_id;
      logic [SLICE_W-1:0]  slice_in;
   } req_type;

   typedef struct packed {
      logic [PROC_W-1:0]   picked_id;
      logic                picked_valid;
      logic [SLICE_W-1:0]  slice_now;
      logic                resched;
      status_type          status;
      logic [COUNT_W-1:0]  queued_count;
   } rsp_type;

endpackage

FILE: rtl/round_robin_run_queue.sv
// A request is registered in s1_ff, its response in rsp_ff. Throughput:
// one command per cycle unless the response stalls; link and slice memories
// are read at transfer, written at execution, with a bypass between them.
// Reset: synchronous, empties the queue, marks every slice as zero and sets
// max_slice to 5, all in the reset cycle.
// ----------------------------------------------------------------------------
// round_robin_run_queue
// Doubly linked run queue of process numbers with a time-slice per process.
// ----------------------------------------------------------------------------
module round_robin_run_queue #(
   parameter int NUM_PROCS = rrq_pkg::NUM_PROCS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rrq_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rrq_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rrq_pkg::SLICE_W-1:0]   csr_wdata
);
   import rrq_pkg::*;

   localparam int DEPTH = (NUM_PROCS < MAX_IDS) ? NUM_PROCS : MAX_IDS;
   localparam int IDX_W = $clog2(DEPTH);

   logic [IDX_W-1:0]   next_link_mem [DEPTH];
   logic [IDX_W-1:0]   prev_link_mem [DEPTH];
   logic [SLICE_W-1:0] slice_mem     [DEPTH];

   logic [DEPTH-1:0]   in_queue_ff, in_queue_in;
   logic [DEPTH-1:0]   slice_valid_ff, slice_valid_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SLICE_W-1:0] max_slice_ff;

   req_type            s1_ff;
   logic               s1_valid_ff, s1_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]   nl_rd_ff, nl_fwd_ff, pl_rd_ff, pl_fwd_ff;
   logic [SLICE_W-1:0] sl_rd_ff, sl_fwd_ff;
   logic               nl_hit_ff, pl_hit_ff, sl_hit_ff;

   logic               nl_we, pl_we, sl_we;
   logic [IDX_W-1:0]   nl_wa, nl_wd, pl_wa, pl_wd, sl_wa;
   logic [SLICE_W-1:0] sl_wd;

   logic               req_fire, s1_go;
   logic [IDX_W-1:0]   req_idx, p_idx, nx, pv;
   logic               ok_id, queued;
   logic [SLICE_W-1:0] slice_cur, slice_clamp, slice_dec;
   logic [COUNT_W-1:0] count_dec;

   assign csr_ready = 1'b1;
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;
   assign req_idx   = req_data.proc_id[IDX_W-1:0];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign p_idx     = s1_ff.proc_id[IDX_W-1:0];
   assign ok_id     = 32'(s1_ff.proc_id) < NUM_PROCS;
   assign queued    = ok_id && in_queue_ff[p_idx];
   assign nx        = nl_hit_ff ? nl_fwd_ff : nl_rd_ff;
   assign pv        = pl_hit_ff ? pl_fwd_ff : pl_rd_ff;
   assign slice_cur = slice_valid_ff[p_idx] ? (sl_hit_ff ? sl_fwd_ff : sl_rd_ff)
                                            : '0;
   assign slice_clamp = (s1_ff.slice_in == '0 || s1_ff.slice_in > max_slice_ff)
                        ? max_slice_ff : s1_ff.slice_in;
   assign slice_dec   = (slice_cur != '0) ? slice_cur - 1'b1 : '0;
   assign count_dec   = count_ff - 1'b1;

   // command execution
   always_comb begin
      in_queue_in    = in_queue_ff;
      slice_valid_in = slice_valid_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      nl_we = 1'b0;  nl_wa = tail_ff;  nl_wd = p_idx;
      pl_we = 1'b0;  pl_wa = p_idx;    pl_wd = tail_ff;
      sl_we = 1'b0;  sl_wa = p_idx;    sl_wd = slice_clamp;
      rsp_in = '0;
      rsp_in.status = STATUS_OK;
      case (s1_ff.command)
         CMD_ENQUEUE: begin
            if (!ok_id || queued) begin
               rsp_in.status    = STATUS_QUEUED;
               rsp_in.slice_now = ok_id ? slice_cur : '0;
            end else begin
               sl_we = 1'b1;
               slice_valid_in[p_idx] = 1'b1;
               if (count_ff == '0) begin
                  head_in = p_idx;
               end else begin
                  nl_we = 1'b1;
               end
               pl_we    = 1'b1;
               tail_in  = p_idx;
               in_queue_in[p_idx] = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in.slice_now = slice_clamp;
            end
         end
         CMD_DEQUEUE: begin
            if (!queued) begin
               rsp_in.status = STATUS_NOT_QUEUED;
            end else begin
               if (p_idx == head_ff) begin
                  head_in = nx;
               end else begin
                  nl_we = 1'b1;
                  nl_wa = pv;
                  nl_wd = nx;
               end
               if (p_idx == tail_ff) begin
                  tail_in = pv;
               end else begin
                  pl_we = 1'b1;
                  pl_wa = nx;
                  pl_wd = pv;
               end
               in_queue_in[p_idx] = 1'b0;
               count_in = count_dec;
               if (count_dec == '0) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end
         end
         CMD_PICK: begin
            if (count_ff != '0) begin
               rsp_in.picked_id    = PROC_W'(head_ff);
               rsp_in.picked_valid = 1'b1;
            end
         end
         CMD_TICK: begin
            if (ok_id) begin
               sl_we = 1'b1;
               sl_wd = slice_dec;
               slice_valid_in[p_idx] = 1'b1;
               rsp_in.slice_now = slice_dec;
               rsp_in.resched   = (slice_dec == '0);
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      rsp_in.queued_count = count_in;
      if (!s1_go) begin
         nl_we = 1'b0;
         pl_we = 1'b0;
         sl_we = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
      rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ready);
   end

   // link and slice memories
   always_ff @(posedge clock) begin
      if (nl_we) begin
         next_link_mem[nl_wa] <= nl_wd;
      end
      if (pl_we) begin
         prev_link_mem[pl_wa] <= pl_wd;
      end
      if (sl_we) begin
         slice_mem[sl_wa] <= sl_wd;
      end
      if (req_fire) begin
         nl_rd_ff <= next_link_mem[req_idx];
         pl_rd_ff <= prev_link_mem[req_idx];
         sl_rd_ff <= slice_mem[req_idx];
      end
   end

   // bypass of the write made in the same cycle as the read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         nl_hit_ff <= nl_we && (nl_wa == req_idx);
         pl_hit_ff <= pl_we && (pl_wa == req_idx);
         sl_hit_ff <= sl_we && (sl_wa == req_idx);
         nl_fwd_ff <= nl_wd;
         pl_fwd_ff <= pl_wd;
         sl_fwd_ff <= sl_wd;
         s1_ff     <= req_data;
      end
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_queue_ff    <= '0;
         slice_valid_ff <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_slice_ff   <= MAX_SLICE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            in_queue_ff    <= in_queue_in;
            slice_valid_ff <= slice_valid_in;
            head_ff        <= head_in;
            tail_ff        <= tail_in;
            count_ff       <= count_in;
         end
         if (csr_valid && csr_ready) begin
            max_slice_ff <= csr_wdata;
         end
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("queue count above depth");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(in_queue_ff) == 32'(count_ff))
      else $error("queue count differs from queued flags");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == '0 && tail_ff == '0)
      else $error("empty queue with nonzero head or tail");

   a_pick_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.picked_valid |-> rsp_ff.queued_count != '0)
      else $error("pick reported on empty queue");
`endif

endmodule

FILE: test/rrq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_checker
// Watches the request, response and csr channels of the run queue. It keeps
// its own copy of the queue links, per-process slices and the slice limit,
// works out the response of every request transfer, and compares each
// response transfer field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module rrq_checker #(
   parameter int NUM_PROCS = rrq_pkg::NUM_PROCS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  rrq_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  rrq_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [rrq_pkg::SLICE_W-1:0]  csr_wdata,
   output int                           fail_count,
   output int                           pending,
   output int                           rsp_count,
   output int                           peak_depth,
   output int                           resched_count,
   output int                           error_count
);
   import rrq_pkg::*;

   logic                on_queue   [MAX_IDS];
   logic [PROC_W-1:0]   link_next  [MAX_IDS];
   logic [PROC_W-1:0]   link_prev  [MAX_IDS];
   logic [SLICE_W-1:0]  slice_left [MAX_IDS];
   logic [PROC_W-1:0]   head;
   logic [PROC_W-1:0]   tail;
   logic [COUNT_W-1:0]  depth;
   logic [SLICE_W-1:0]  slice_cap;

   rsp_type owed_rsps[$];

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: response %s got %0d expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   function automatic rsp_type run_queue_step(input req_type r);
      rsp_type             o;
      logic [PROC_W-1:0]   p;
      logic [PROC_W-1:0]   nx;
      logic [PROC_W-1:0]   pv;
      logic [SLICE_W-1:0]  s;
      logic                id_ok;
      o = '0;
      o.status = STATUS_OK;
      p = r.proc_id;
      s = r.slice_in;
      id_ok = (int'(p) < NUM_PROCS);
      case (r.command)
         CMD_ENQUEUE: begin
            if (!id_ok || on_queue[p]) begin
               o.status = STATUS_QUEUED;
               if (id_ok) o.slice_now = slice_left[p];
            end else begin
               if (s == 0 || s > slice_cap) s = slice_cap;
               slice_left[p] = s;
               if (depth == 0) head = p;
               else link_next[tail] = p;
               link_prev[p] = tail;
               link_next[p] = p;
               tail = p;
               on_queue[p] = 1'b1;
               depth = depth + 1'b1;
               o.slice_now = s;
            end
         end
         CMD_DEQUEUE: begin
            if (!id_ok || !on_queue[p]) begin
               o.status = STATUS_NOT_QUEUED;
            end else begin
               nx = link_next[p];
               pv = link_prev[p];
               if (p == head) head = nx;
               else link_next[pv] = nx;
               if (p == tail) tail = pv;
               else link_prev[nx] = pv;
               on_queue[p] = 1'b0;
               depth = depth - 1'b1;
               if (depth == 0) begin
                  head = '0;
                  tail = '0;
               end
            end
         end
         CMD_PICK: begin
            if (depth != 0) begin
               o.picked_id    = head;
               o.picked_valid = 1'b1;
            end
         end
         default: begin
            if (id_ok) begin
               s = slice_left[p];
               if (s != 0) s = s - 1'b1;
               slice_left[p] = s;
               o.slice_now = s;
               o.resched = (s == 0);
            end
         end
      endcase
      o.queued_count = depth;
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         for (int k = 0; k < MAX_IDS; k++) begin
            on_queue[k]   = 1'b0;
            link_next[k]  = '0;
            link_prev[k]  = '0;
            slice_left[k] = '0;
         end
         head          = '0;
         tail          = '0;
         depth         = '0;
         slice_cap     = MAX_SLICE_RESET;
         fail_count    = 0;
         rsp_count     = 0;
         peak_depth    = 0;
         resched_count = 0;
         error_count   = 0;
         owed_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (owed_rsps.size() == 0) begin
               report_mismatch("transfer with nothing owed", 1, 0);
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_data.picked_id !== want.picked_id)
                  report_mismatch("picked_id", int'(rsp_data.picked_id),
                                  int'(want.picked_id));
               if (rsp_data.picked_valid !== want.picked_valid)
                  report_mismatch("picked_valid", int'(rsp_data.picked_valid),
                                  int'(want.picked_valid));
               if (rsp_data.slice_now !== want.slice_now)
                  report_mismatch("slice_now", int'(rsp_data.slice_now),
                                  int'(want.slice_now));
               if (rsp_data.resched !== want.resched)
                  report_mismatch("resched", int'(rsp_data.resched), int'(want.resched));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", int'(rsp_data.status), int'(want.status));
               if (rsp_data.queued_count !== want.queued_count)
                  report_mismatch("queued_count", int'(rsp_data.queued_count),
                                  int'(want.queued_count));
            end
         end
         if (csr_valid && csr_ready) slice_cap = csr_wdata;
         if (req_valid && req_ready) begin
            fresh = run_queue_step(req_data);
            if (fresh.status != STATUS_OK) error_count++;
            if (fresh.resched) resched_count++;
            if (int'(depth) > peak_depth) peak_depth = int'(depth);
            owed_rsps.push_back(fresh);
         end
      end
      pending = owed_rsps.size();
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the round-robin run queue with a directed opening, a full fill and
// drain of all process numbers, and biased random command streams under
// several slice limits, with random gaps on both sides in all but one. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import rrq_pkg::*;

   localparam int STALL_LIMIT = 1000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [SLICE_W-1:0]  csr_wdata;

   int fail_count;
   int pending;
   int rsp_count;
   int peak_depth;
   int resched_count;
   int error_count;
   int cap_settings;
   int quiet_cycles;
   bit gaps_on;
   bit shadow_queued [MAX_IDS];
   logic [PROC_W-1:0] id_order [MAX_IDS];

   round_robin_run_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   rrq_checker rrq_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .rsp_count     (rsp_count),
      .peak_depth    (peak_depth),
      .resched_count (resched_count),
      .error_count   (error_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= !gaps_on || ($urandom_range(99) >= 24);
   end

   // no transfer on any channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d responses owed",
                  STALL_LIMIT, pending);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cmd(input cmd_type c, input logic [PROC_W-1:0] p,
                           input logic [SLICE_W-1:0] s);
      req_type item;
      item.command  = c;
      item.proc_id  = p;
      item.slice_in = s;
      while (gaps_on && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (c == CMD_ENQUEUE) shadow_queued[p] = 1'b1;
      else if (c == CMD_DEQUEUE) shadow_queued[p] = 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_slice_cap(input logic [SLICE_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cap_settings++;
   endtask

   function automatic logic [PROC_W-1:0] choose_id(input bit want_queued);
      logic [PROC_W-1:0] p;
      p = PROC_W'($urandom_range(MAX_IDS - 1));
      for (int k = 0; k < MAX_IDS; k++) begin
         if (shadow_queued[p] == want_queued) return p;
         p = p + 1'b1;
      end
      return p;
   endfunction

   function automatic logic [SLICE_W-1:0] choose_slice();
      case ($urandom_range(3))
         0: return '0;
         1: return SLICE_W'($urandom_range(8));
         default: return SLICE_W'($urandom_range(255));
      endcase
   endfunction

   task automatic shuffle_id_order();
      logic [PROC_W-1:0] t;
      int j;
      for (int i = 0; i < MAX_IDS; i++) id_order[i] = PROC_W'(i);
      for (int i = MAX_IDS - 1; i > 0; i--) begin
         j = int'($urandom_range(i));
         t = id_order[i];
         id_order[i] = id_order[j];
         id_order[j] = t;
      end
   endtask

   task automatic random_burst(input int n);
      int roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 35)
            send_cmd(CMD_ENQUEUE, choose_id($urandom_range(9) < 2), choose_slice());
         else if (roll < 62)
            send_cmd(CMD_DEQUEUE, choose_id($urandom_range(9) < 8),
                     SLICE_W'($urandom_range(255)));
         else if (roll < 77)
            send_cmd(CMD_PICK, PROC_W'($urandom_range(63)), SLICE_W'($urandom_range(255)));
         else
            send_cmd(CMD_TICK, choose_id($urandom_range(9) < 7),
                     SLICE_W'($urandom_range(255)));
      end
   endtask

   // every process number in, then every one out, both in random order
   task automatic fill_and_empty();
      shuffle_id_order();
      for (int i = 0; i < MAX_IDS; i++) begin
         send_cmd(CMD_ENQUEUE, id_order[i], choose_slice());
         if ($urandom_range(7) == 0)
            send_cmd(CMD_PICK, PROC_W'($urandom_range(63)), SLICE_W'($urandom_range(255)));
         if ($urandom_range(5) == 0)
            send_cmd(CMD_TICK, id_order[$urandom_range(i)], SLICE_W'($urandom_range(255)));
      end
      send_cmd(CMD_ENQUEUE, id_order[$urandom_range(63)], 8'd255);
      send_cmd(CMD_PICK, 6'd0, 8'd0);
      shuffle_id_order();
      for (int i = 0; i < MAX_IDS; i++) begin
         send_cmd(CMD_DEQUEUE, id_order[i], SLICE_W'($urandom_range(255)));
         if ($urandom_range(5) == 0)
            send_cmd(CMD_PICK, PROC_W'($urandom_range(63)), SLICE_W'($urandom_range(255)));
      end
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_wdata    = '0;
      gaps_on      = 1'b0;
      cap_settings = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      gaps_on <= 1'b1;

      // directed opening at the reset slice limit
      send_cmd(CMD_PICK,    6'd0,  8'd0);
      send_cmd(CMD_DEQUEUE, 6'd0,  8'd0);
      send_cmd(CMD_TICK,    6'd63, 8'd0);
      send_cmd(CMD_ENQUEUE, 6'd0,  8'd0);
      send_cmd(CMD_ENQUEUE, 6'd63, 8'd255);
      send_cmd(CMD_ENQUEUE, 6'd10, 8'd3);
      send_cmd(CMD_ENQUEUE, 6'd0,  8'd2);
      send_cmd(CMD_PICK,    6'd63, 8'd255);
      send_cmd(CMD_TICK,    6'd10, 8'd0);
      send_cmd(CMD_TICK,    6'd10, 8'd0);
      send_cmd(CMD_TICK,    6'd10, 8'd0);
      send_cmd(CMD_TICK,    6'd10, 8'd0);
      send_cmd(CMD_DEQUEUE, 6'd63, 8'd0);
      send_cmd(CMD_PICK,    6'd0,  8'd0);
      send_cmd(CMD_DEQUEUE, 6'd0,  8'd0);
      send_cmd(CMD_PICK,    6'd0,  8'd0);
      send_cmd(CMD_ENQUEUE, 6'd42, 8'd5);
      send_cmd(CMD_DEQUEUE, 6'd42, 8'd0);
      send_cmd(CMD_DEQUEUE, 6'd10, 8'd0);
      send_cmd(CMD_PICK,    6'd0,  8'd0);
      send_cmd(CMD_DEQUEUE, 6'd10, 8'd255);
      send_cmd(CMD_ENQUEUE, 6'd21, 8'd170);
      send_cmd(CMD_TICK,    6'd21, 8'd85);

      settle();
      write_slice_cap(8'd0);
      random_burst(30);

      settle();
      write_slice_cap(8'd255);
      fill_and_empty();

      // a long stretch without gaps on either side
      settle();
      write_slice_cap(8'd1);
      gaps_on <= 1'b0;
      random_burst(150);

      settle();
      write_slice_cap(SLICE_W'($urandom_range(2, 254)));
      gaps_on <= 1'b1;
      random_burst(200);

      settle();
      repeat (4) @(negedge clock);
      $display("checked %0d responses under %0d slice limits, queue depth up to %0d",
               rsp_count, cap_settings + 1, peak_depth);
      $display("saw %0d reschedule requests and %0d error statuses",
               resched_count, error_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: round_robin_run_queue.f
rtl/rrq_pkg.sv
rtl/round_robin_run_queue.sv
test/rrq_checker.sv
test/tb_top.sv
